// File: src/lrb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrb_pkg
// Shared constants for the recency tracker: field widths and register map.
// ----------------------------------------------------------------------------
package lrb_pkg;

  // Width of the key field on the input channel
  localparam int unsigned ITEM_KEY_W = 16;
  // Width of the evicted key field on the output channel
  localparam int unsigned EVICT_KEY_W = 16;
  // Width of the capacity limit register
  localparam int unsigned LIMIT_W = 7;

  // Configuration port geometry
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  // Register indexes (byte address = 4 * index)
  localparam logic [0:0] REG_CAPACITY_LIMIT = 1'b0;

endpackage

// File: src/lrb_key_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrb_key_if
// Input channel: one item key per transfer.
// ----------------------------------------------------------------------------
interface lrb_key_if;
  import lrb_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [ITEM_KEY_W-1:0] item_key;

  modport source (output valid, output item_key, input ready);
  modport sink   (input valid, input item_key, output ready);

endinterface

// File: src/lrb_evict_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrb_evict_if
// Result channel: one eviction report per accepted key.
// ----------------------------------------------------------------------------
interface lrb_evict_if;
  import lrb_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   evicted_valid;
  logic [EVICT_KEY_W-1:0] evicted_key;

  modport source (output valid, output evicted_valid, output evicted_key, input ready);
  modport sink   (input valid, input evicted_valid, input evicted_key, output ready);

endinterface

// File: src/lrb_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrb_cell
// One slot of the recency row: holds a key, compares it against the lookup
// key and takes its neighbor's key when the row shifts toward the old end.
// ----------------------------------------------------------------------------
module lrb_cell #(
  parameter int unsigned IDX       = 0,
  parameter int unsigned CNT_W     = 7,
  parameter int unsigned KEY_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 upd,       // row update this cycle
  input  logic [KEY_WIDTH-1:0] key,       // lookup key, also loaded at the front
  input  logic [CNT_W-1:0]     upto,      // last slot that takes its neighbor
  input  logic [CNT_W-1:0]     held,      // occupied slots
  input  logic                 use_next,  // report tail after the shift
  input  logic [KEY_WIDTH-1:0] prev_key,  // key of the newer neighbor
  output logic [KEY_WIDTH-1:0] key_q,
  output logic                 match,
  output logic [KEY_WIDTH-1:0] tail_key
);

  localparam logic [CNT_W-1:0] MY_IDX  = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] MY_NEXT = CNT_W'(IDX + 1);

  logic                 occupied;
  logic                 shift;
  logic [KEY_WIDTH-1:0] key_next;

  // Compare only slots that have been written
  assign occupied = MY_IDX < held;
  assign match    = occupied && (key_q == key);

  // Front slot loads the key, others take the neighbor up to the shift point
  always_comb begin
    key_next = key_q;
    if (IDX == 0) begin
      if (upd) begin
        key_next = key;
      end
    end else if (upd && (MY_IDX <= upto)) begin
      key_next = prev_key;
    end
  end

  assign shift = upd;

  always_ff @(posedge clk) begin
    if (shift) begin
      key_q <= key_next;
    end
  end

  // Drive the oldest occupied key onto the tail bus
  always_comb begin
    tail_key = '0;
    if (MY_NEXT == held) begin
      tail_key = use_next ? key_next : key_q;
    end
  end

endmodule

// File: src/lrb_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrb_cfg
// APB register file holding the capacity limit.
// ----------------------------------------------------------------------------
module lrb_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lrb_pkg::PADDR_W-1:0] paddr,
  input  logic [lrb_pkg::PDATA_W-1:0] pwdata,
  output logic [lrb_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output logic [lrb_pkg::LIMIT_W-1:0] capacity_limit
);
  import lrb_pkg::*;

  logic sel_limit;
  logic wr_en;

  assign pready    = 1'b1;
  assign sel_limit = paddr[PADDR_W-1] == REG_CAPACITY_LIMIT;
  assign wr_en     = psel && penable && pwrite && pready;

  // Register write on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= '0;
    end else if (wr_en && sel_limit) begin
      capacity_limit <= pwdata[LIMIT_W-1:0];
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    if (sel_limit) begin
      prdata = PDATA_W'(capacity_limit);
    end
  end

endmodule

// File: src/lru_recency_bounder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_recency_bounder_core
// Recency-ordered key tracker with a configurable limit and eviction report.
// ----------------------------------------------------------------------------
// Takes one key per clock cycle unless the report register is stalled and
// returns one eviction report per key, in the cycle after the transfer,
// through a result register; a new key is taken while the previous report
// waits as long as the register is freed in that cycle. The rate is set by
// the row of CAPACITY cells, each of which compares its key with the lookup
// key and shifts toward the old end in the same cycle. A limit of zero leaves
// the held keys untouched and reports no eviction; a limit above CAPACITY acts
// as CAPACITY. Lowering the limit does not flush keys: each later key evicts
// one oldest key; only a hit can lower the count. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module lru_recency_bounder_core #(
  parameter int unsigned CAPACITY  = 64,
  parameter int unsigned KEY_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  lrb_key_if.sink                     key_in,
  lrb_evict_if.source                 evict_out,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lrb_pkg::PADDR_W-1:0] paddr,
  input  logic [lrb_pkg::PDATA_W-1:0] pwdata,
  output logic [lrb_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import lrb_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned EFF_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  logic [LIMIT_W-1:0]   capacity_limit;
  logic [EFF_W-1:0]     eff;
  logic [EFF_W-1:0]     held_ext;
  logic [CNT_W-1:0]     held_count;
  logic [CNT_W-1:0]     held_count_next;
  logic [KEY_WIDTH-1:0] key;
  logic                 take;
  logic                 upd;
  logic                 found;
  logic                 full;
  logic [CNT_W-1:0]     hit_idx;
  logic [CNT_W-1:0]     upto;
  logic                 ev;
  logic [KEY_WIDTH-1:0] ev_key;

  logic [CAPACITY-1:0]  match;
  logic [KEY_WIDTH-1:0] cell_key  [CAPACITY];
  logic [KEY_WIDTH-1:0] cell_tail [CAPACITY];

  // Configuration registers
  lrb_cfg u_cfg (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .capacity_limit (capacity_limit)
  );

  // Accept a key when the result register is free or drains this cycle
  assign key_in.ready = !evict_out.valid || evict_out.ready;
  assign take         = key_in.valid && key_in.ready;
  assign key          = KEY_WIDTH'(key_in.item_key);

  // Saturate the limit at the row length
  assign eff      = (EFF_W'(capacity_limit) > EFF_W'(CAPACITY)) ?
                    EFF_W'(CAPACITY) : EFF_W'(capacity_limit);
  assign held_ext = EFF_W'(held_count);
  assign upd      = take && (eff != '0);
  assign found    = |match;
  assign full     = held_ext >= eff;

  // Encode the single matching slot
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (match[i]) begin
        hit_idx = hit_idx | CNT_W'(i);
      end
    end
  end

  // Pick the shift point and the new count
  always_comb begin
    upto            = held_count;
    ev              = 1'b0;
    held_count_next = held_count;
    if (found) begin
      upto = hit_idx;
      if (held_ext > eff) begin
        ev              = 1'b1;
        held_count_next = held_count - CNT_W'(1);
      end
    end else if (full) begin
      upto = held_count - CNT_W'(1);
      ev   = 1'b1;
    end else begin
      held_count_next = held_count + CNT_W'(1);
    end
  end

  // Row of key cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    lrb_cell #(
      .IDX       (g),
      .CNT_W     (CNT_W),
      .KEY_WIDTH (KEY_WIDTH)
    ) u_cell (
      .clk      (clk),
      .upd      (upd),
      .key      (key),
      .upto     (upto),
      .held     (held_count),
      .use_next (found),
      .prev_key ((g == 0) ? key : cell_key[(g == 0) ? 0 : g - 1]),
      .key_q    (cell_key[g]),
      .match    (match[g]),
      .tail_key (cell_tail[g])
    );
  end

  // Collect the oldest key from the tail bus
  always_comb begin
    ev_key = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      ev_key = ev_key | cell_tail[i];
    end
  end

  // Track the occupied count
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
    end else if (upd) begin
      held_count <= held_count_next;
    end
  end

  // Hold the report until the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      evict_out.valid <= 1'b0;
    end else if (take) begin
      evict_out.valid <= 1'b1;
    end else if (evict_out.ready) begin
      evict_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      evict_out.evicted_valid <= upd && ev;
      evict_out.evicted_key   <= (upd && ev) ? EVICT_KEY_W'(ev_key) : '0;
    end
  end

  // Count never passes the row length
  a_held_bound : assert property (@(posedge clk) disable iff (rst)
    held_count <= CNT_W'(CAPACITY))
    else $error("held count above capacity");

  // Held keys are distinct, so at most one slot matches
  a_one_match : assert property (@(posedge clk) disable iff (rst)
    $onehot0(match))
    else $error("more than one slot matches the key");

  // A disabled tracker keeps its count
  a_limit_zero : assert property (@(posedge clk) disable iff (rst)
    (take && capacity_limit == '0) |=> $stable(held_count))
    else $error("count changed with tracking disabled");

  // An eviction needs something held
  a_evict_held : assert property (@(posedge clk) disable iff (rst)
    (upd && ev) |-> (held_count != '0))
    else $error("eviction from an empty row");

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Recency tracker check: keys in, eviction reports out, limit over APB.
// A shadow recency list predicts each eviction report when its key transfers;
// a checker compares every report in order. Directed cases cover the
// disabled limit, hits and misses at both ends of the list, and lowering and
// raising the limit. Random phases then sweep the limit, including the
// saturating values, with random idling on both channels and one long
// back-pressure stretch on the report channel.
// ----------------------------------------------------------------------------
module testbench;
  import lrb_pkg::*;

  localparam int unsigned CAPACITY      = 64;
  localparam int          IDLE_PERCENT  = 26;
  localparam int          HOLD_CYCLES   = 200;
  localparam int          STALL_LIMIT   = 5000;
  localparam logic [PADDR_W-1:0] ADDR_CAPACITY_LIMIT = PADDR_W'(4 * REG_CAPACITY_LIMIT);

  typedef struct packed {
    logic                   evicted_valid;
    logic [EVICT_KEY_W-1:0] evicted_key;
  } evict_report_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  lrb_key_if   key_ch ();
  lrb_evict_if evict_ch ();

  lru_recency_bounder_core #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (ITEM_KEY_W)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .key_in    (key_ch),
    .evict_out (evict_ch),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Shadow of the block state
  logic [ITEM_KEY_W-1:0] tracked_keys [CAPACITY];
  int                    tracked_count = 0;
  logic [LIMIT_W-1:0]    limit_shadow  = '0;

  evict_report_t pending_evictions [$];
  int            failures   = 0;
  int            idle_count = 0;
  bit            calm       = 1'b0;
  int            hold_req   = 0;
  int            hold_seen  = 0;
  int            hold_left  = 0;

  // Clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shift entries [0, upto) toward the old end and put key at the front
  function automatic void shift_in(int upto, logic [ITEM_KEY_W-1:0] key);
    for (int i = upto; i > 0; i--) begin
      if (i < CAPACITY) tracked_keys[i] = tracked_keys[i-1];
    end
    tracked_keys[0] = key;
  endfunction

  // Update the shadow list with one key and return the expected report
  function automatic evict_report_t track_key(logic [ITEM_KEY_W-1:0] key);
    evict_report_t rep;
    int            eff;
    int            hit;
    bit            found;
    rep   = '0;
    eff   = (limit_shadow > CAPACITY) ? CAPACITY : int'(limit_shadow);
    found = 1'b0;
    hit   = 0;
    if (eff == 0) return rep;
    for (int i = 0; i < tracked_count; i++) begin
      if (!found && tracked_keys[i] == key) begin
        found = 1'b1;
        hit   = i;
      end
    end
    if (found) begin
      shift_in(hit, key);
      if (tracked_count > eff) begin
        rep.evicted_valid = 1'b1;
        rep.evicted_key   = tracked_keys[tracked_count-1];
        tracked_count--;
      end
    end else if (tracked_count + 1 > eff) begin
      rep.evicted_valid = 1'b1;
      rep.evicted_key   = tracked_keys[tracked_count-1];
      shift_in(tracked_count - 1, key);
    end else begin
      shift_in(tracked_count, key);
      tracked_count++;
    end
    return rep;
  endfunction

  // Report sink: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      evict_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      evict_ch.ready <= 1'b0;
      hold_left      <= hold_left - 1;
    end else if (hold_seen != hold_req) begin
      hold_seen      <= hold_req;
      hold_left      <= HOLD_CYCLES;
      evict_ch.ready <= 1'b0;
    end else begin
      evict_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  // Check reports, predict on key transfers, track limit writes, watchdog
  always @(posedge clk) begin : monitor
    bit            progressed;
    evict_report_t exp_rep;
    progressed = 1'b0;
    if (!rst) begin
      if (evict_ch.valid && evict_ch.ready) begin
        progressed = 1'b1;
        if (pending_evictions.size() == 0) begin
          $error("unexpected report: evicted_valid=%0d evicted_key=%h",
                 evict_ch.evicted_valid, evict_ch.evicted_key);
          failures++;
        end else begin
          exp_rep = pending_evictions.pop_front();
          if (evict_ch.evicted_valid !== exp_rep.evicted_valid) begin
            $error("evicted_valid: expected %0d, actual %0d",
                   exp_rep.evicted_valid, evict_ch.evicted_valid);
            failures++;
          end
          if (evict_ch.evicted_key !== exp_rep.evicted_key) begin
            $error("evicted_key: expected %h, actual %h",
                   exp_rep.evicted_key, evict_ch.evicted_key);
            failures++;
          end
        end
      end
      if (key_ch.valid && key_ch.ready) begin
        progressed = 1'b1;
        pending_evictions = {pending_evictions, track_key(key_ch.item_key)};
      end
      if (psel && penable && pwrite && pready) begin
        progressed = 1'b1;
        if (paddr == ADDR_CAPACITY_LIMIT) limit_shadow = pwdata[LIMIT_W-1:0];
      end
      if (progressed) begin
        idle_count = 0;
      end else begin
        idle_count++;
        if (idle_count >= STALL_LIMIT) begin
          $display("Test completed with failures");
          $finish;
        end
      end
    end
  end

  // Offer one key and hold it until the transfer
  task automatic offer_key(input logic [ITEM_KEY_W-1:0] key);
    while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
      key_ch.valid <= 1'b0;
      @(posedge clk);
    end
    key_ch.valid    <= 1'b1;
    key_ch.item_key <= key;
    @(posedge clk);
    while (!key_ch.ready) @(posedge clk);
  endtask

  // Drop valid and wait until every report has come back
  task automatic wait_for_reports();
    key_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_evictions.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  // APB write of the limit register, only once the block is idle
  task automatic write_capacity_limit(input int value);
    wait_for_reports();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_CAPACITY_LIMIT;
    pwdata  <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly keys from a small pool so hits are frequent, sometimes any key
  function automatic logic [ITEM_KEY_W-1:0] pick_key(logic [ITEM_KEY_W-1:0] base, int pool);
    if ($urandom_range(0, 99) < 85) return base + ITEM_KEY_W'($urandom_range(0, pool - 1));
    return ITEM_KEY_W'($urandom);
  endfunction

  task automatic run_phase(input int limit, input int n_items, input int pool, input bit quiet);
    logic [ITEM_KEY_W-1:0] base;
    base = ITEM_KEY_W'($urandom);
    write_capacity_limit(limit);
    calm = quiet;
    repeat (n_items) offer_key(pick_key(base, pool));
    calm = 1'b0;
  endtask

  // Limit zero at reset and when written: keys are ignored
  task automatic test_disabled_limit();
    offer_key(16'h0000);
    offer_key(16'hFFFF);
    offer_key(16'h5A5A);
    write_capacity_limit(0);
    offer_key(16'hA5A5);
  endtask

  // Hits and misses at both ends, lowering the limit, raising it after zero
  task automatic test_recency_order();
    write_capacity_limit(3);
    offer_key(16'd10);
    offer_key(16'd20);
    offer_key(16'd30);
    offer_key(16'd10);      // hit on the oldest entry
    offer_key(16'd40);      // miss when full: evict oldest
    offer_key(16'd40);      // hit on the front entry
    offer_key(16'hFFFF);
    write_capacity_limit(1); // lowered below the held count
    offer_key(16'd10);      // hit at the tail, then one eviction
    offer_key(16'h0000);    // miss: evict one, count unchanged
    offer_key(16'd10);
    write_capacity_limit(0);
    offer_key(16'd10);
    write_capacity_limit(4); // keys held before are still used
    offer_key(16'd10);
    offer_key(16'h0000);
    offer_key(16'h8001);
  endtask

  // Random phases over many limits, saturating ones included
  task automatic test_limit_sweep();
    int mid;
    mid = $urandom_range(3, 63);
    run_phase(64, 200, 90, 1'b1);
    run_phase(127, 200, 100, 1'b0);
    run_phase(65, 150, 80, 1'b0);
    run_phase(1, 120, 3, 1'b0);
    run_phase(2, 120, 4, 1'b0);
    run_phase(0, 30, 8, 1'b0);
    run_phase(8, 150, 12, 1'b0);
    run_phase(mid, 150, mid + mid / 2 + 1, 1'b0);
    run_phase(40, 150, 60, 1'b0);
    run_phase(5, 150, 8, 1'b0);
    run_phase(30, 100, 40, 1'b0);
  endtask

  // Long report stall while keys keep coming, so the input backs up
  task automatic test_backpressure();
    logic [ITEM_KEY_W-1:0] base;
    base = ITEM_KEY_W'($urandom);
    write_capacity_limit(16);
    calm = 1'b1;
    hold_req++;
    repeat (30) offer_key(pick_key(base, 24));
    calm = 1'b0;
  endtask

  initial begin
    rst             <= 1'b1;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    key_ch.valid    <= 1'b0;
    key_ch.item_key <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_disabled_limit();
    test_recency_order();
    test_limit_sweep();
    test_backpressure();

    wait_for_reports();
    repeat (4) @(posedge clk);
    if (failures == 0 && pending_evictions.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
